// ===== sv/grma_pkg.sv =====
// Shared types and constants for the grid region merge/average block.
// No dependencies.
`timescale 1ns / 1ps

package grma_pkg;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_CLR      = 15'b000000000000010,
        S_SCAN_RD  = 15'b000000000000100,
        S_SCAN_CHK = 15'b000000000001000,
        S_NB_RD    = 15'b000000000010000,
        S_NB_CHK   = 15'b000000000100000,
        S_POP_RD   = 15'b000000001000000,
        S_POP_LST  = 15'b000000010000000,
        S_POP_CUR  = 15'b000000100000000,
        S_DIV      = 15'b000001000000000,
        S_WB_RD    = 15'b000010000000000,
        S_WB_LST   = 15'b000100000000000,
        S_WB_W     = 15'b001000000000000,
        S_PASS_END = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } t_state;

    // neighbor directions, visited in this order
    localparam logic [1:0] K_UP    = 2'd0;
    localparam logic [1:0] K_DOWN  = 2'd1;
    localparam logic [1:0] K_LEFT  = 2'd2;
    localparam logic [1:0] K_RIGHT = 2'd3;

    // register addresses (word index)
    localparam logic [1:0] REG_SIDE   = 2'd0;
    localparam logic [1:0] REG_DLOW   = 2'd1;
    localparam logic [1:0] REG_DHIGH  = 2'd2;

    localparam logic [15:0] DAY_MAX = 16'hFFFF;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

// ===== sv/grma_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module grma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/grma_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Uses grma_pkg for the start/done control struct.
`timescale 1ns / 1ps

module grma_div #(
    parameter int N_W = 28,
    parameter int D_W = 13
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  grma_pkg::t_div_ctl      i_ctl,
    output grma_pkg::t_div_ctl      o_ctl,
    input  logic [N_W-1:0]          i_dividend,
    input  logic [D_W-1:0]          i_divisor,
    output logic [N_W-1:0]          o_quot
);
    import grma_pkg::*;

    localparam int CNT_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [D_W:0]     r_rem;
    logic [D_W-1:0]   r_den;
    logic [N_W-1:0]   r_q;
    logic [D_W:0]     trial;
    logic             fits;

    assign trial = {r_rem[D_W-1:0], r_q[N_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_q   <= {r_q[N_W-2:0], fits};
        end
    end

    assign o_ctl.start = 1'b0;
    assign o_ctl.done  = r_done;
    assign o_quot      = r_q;

endmodule

// ===== sv/grid_region_merge_average_unit.sv =====
// Top level: grid load, flood-fill passes over RAM-held grid, day count out.
// Depends on grma_pkg, grma_ram, grma_div.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------
//  in       | i_in_valid / o_in_stall  | i_cell_value, i_last_cell
//  out      | o_out_valid / i_out_stall| o_day_count
//  config   | APB psel/penable/pwrite  | paddr, pwdata, prdata
//
// Loading accepts one cell beat per cycle. After the last cell each pass clears
// the visited RAM and scans every cell: each cell is read and checked, and for
// an unvisited cell each in-grid neighbor is read and checked while off-grid
// directions are skipped. A region pops each listed cell, reads its value and
// probes its neighbors, then runs the mean divider and writes back each cell.
// Reset is synchronous, active low; the RAMs are not cleared. The input stalls
// from the last cell until the day count is loaded into the output register.
`timescale 1ns / 1ps

module grid_region_merge_average_unit #(
    parameter int MAX_SIDE   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_cell_value,
    input  logic                  i_last_cell,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [15:0]           o_day_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import grma_pkg::*;

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W = CELLS > 1 ? $clog2(CELLS) : 1;
    localparam int TOT_W  = $clog2(CELLS + 1);
    localparam int RC_W   = MAX_SIDE > 1 ? $clog2(MAX_SIDE) : 1;
    localparam int N_W    = RC_W + 1;
    localparam int SUM_W  = VALUE_BITS + TOT_W;
    localparam int DW     = VALUE_BITS > 16 ? VALUE_BITS : 16;
    localparam int FL_W   = RC_W + N_W + 1;

    t_state r_state;

    logic [6:0]  r_side;
    logic [15:0] r_dlow;
    logic [15:0] r_dhigh;

    // config port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side  <= 7'd64;
            r_dlow  <= 16'd0;
            r_dhigh <= 16'hFFFF;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_SIDE:  r_side  <= pwdata[6:0];
                REG_DLOW:  r_dlow  <= pwdata[15:0];
                REG_DHIGH: r_dhigh <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SIDE:  prdata = {25'd0, r_side};
            REG_DLOW:  prdata = {16'd0, r_dlow};
            REG_DHIGH: prdata = {16'd0, r_dhigh};
            default:   prdata = 32'd0;
        endcase
    end

    // effective side and cell count
    logic [8:0]       side_ext;
    logic [N_W-1:0]   n_eff;
    logic [TOT_W-1:0] total;
    logic [2*N_W-1:0] total_full;
    assign side_ext = {2'b00, r_side};
    always_comb begin
        if (side_ext == 9'd0) begin
            n_eff = N_W'(1);
        end else if (side_ext > 9'(MAX_SIDE)) begin
            n_eff = N_W'(MAX_SIDE);
        end else begin
            n_eff = side_ext[N_W-1:0];
        end
    end
    assign total_full = n_eff * n_eff;
    assign total      = total_full[TOT_W-1:0];

    function automatic logic [CELL_W-1:0] f_flat(input logic [RC_W-1:0] row,
                                                 input logic [RC_W-1:0] col,
                                                 input logic [N_W-1:0] n);
        logic [FL_W-1:0] t;
        t = FL_W'(row) * FL_W'(n) + FL_W'(col);
        return t[CELL_W-1:0];
    endfunction

    // RAM ports
    logic                  g_we, v_we, l_we;
    logic [CELL_W-1:0]     g_waddr, g_raddr, v_waddr, v_raddr, l_waddr, l_raddr;
    logic [VALUE_BITS-1:0] g_wdata, grid_q;
    logic                  v_wdata, vis_q;
    logic [2*RC_W-1:0]     l_wdata, list_q;

    grma_ram #(.WIDTH(VALUE_BITS), .DEPTH(CELLS)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(g_raddr), .o_rdata(grid_q)
    );
    grma_ram #(.WIDTH(1), .DEPTH(CELLS)) u_vis (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(vis_q)
    );
    grma_ram #(.WIDTH(2*RC_W), .DEPTH(CELLS)) u_list (
        .i_clk(i_clk), .i_we(l_we), .i_waddr(l_waddr), .i_wdata(l_wdata),
        .i_raddr(l_raddr), .o_rdata(list_q)
    );

    // working registers
    logic [TOT_W-1:0]      r_load;
    logic [TOT_W-1:0]      r_sidx;
    logic [RC_W-1:0]       r_sr, r_sc, r_cr, r_cc, r_nr, r_nc;
    logic [CELL_W-1:0]     r_nflat, r_wflat;
    logic [1:0]            r_k;
    logic                  r_bfs;
    logic [VALUE_BITS-1:0] r_gcur, r_mean;
    logic [TOT_W-1:0]      r_head, r_tail, r_wi;
    logic [SUM_W-1:0]      r_sum;
    logic                  r_joined, r_changed;
    logic [15:0]           r_days;
    logic                  r_out_valid;
    logic [15:0]           r_day_out;
    logic                  r_div_go;

    // neighbor of current cell
    logic            nb_ok;
    logic [RC_W-1:0] nb_r, nb_c;
    always_comb begin
        nb_r  = r_cr;
        nb_c  = r_cc;
        nb_ok = 1'b0;
        case (r_k)
            K_UP: begin
                nb_ok = r_cr != '0;
                nb_r  = r_cr - 1'b1;
            end
            K_DOWN: begin
                nb_ok = ({1'b0, r_cr} + 1'b1) < n_eff;
                nb_r  = r_cr + 1'b1;
            end
            K_LEFT: begin
                nb_ok = r_cc != '0;
                nb_c  = r_cc - 1'b1;
            end
            K_RIGHT: begin
                nb_ok = ({1'b0, r_cc} + 1'b1) < n_eff;
                nb_c  = r_cc + 1'b1;
            end
            default: ;
        endcase
    end

    // join test against the neighbor just read
    logic [DW-1:0] a_ext, b_ext, diff;
    logic          join_ok;
    assign a_ext   = DW'(r_gcur);
    assign b_ext   = DW'(grid_q);
    assign diff    = a_ext > b_ext ? a_ext - b_ext : b_ext - a_ext;
    assign join_ok = !vis_q && diff >= DW'(r_dlow) && diff <= DW'(r_dhigh);

    // scan cursor advance
    logic            scan_end;
    logic            col_wrap;
    assign scan_end = (r_sidx + 1'b1) == total;
    assign col_wrap = ({1'b0, r_sc} + 1'b1) == n_eff;

    logic [CELL_W-1:0] list_flat;
    assign list_flat = f_flat(list_q[2*RC_W-1:RC_W], list_q[RC_W-1:0], n_eff);

    logic k_last;
    assign k_last = r_k == K_RIGHT;

    logic in_acc, out_acc;
    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;

    t_div_ctl          div_in, div_out;
    logic [SUM_W-1:0]  quot;
    assign div_in.start = r_div_go;
    assign div_in.done  = 1'b0;

    grma_div #(.N_W(SUM_W), .D_W(TOT_W)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(div_in), .o_ctl(div_out),
        .i_dividend(r_sum), .i_divisor(r_tail), .o_quot(quot)
    );

    // RAM port selection
    always_comb begin
        g_we    = 1'b0;
        g_waddr = r_load[CELL_W-1:0];
        g_wdata = i_cell_value;
        g_raddr = r_sidx[CELL_W-1:0];
        v_we    = 1'b0;
        v_waddr = r_sidx[CELL_W-1:0];
        v_wdata = 1'b0;
        v_raddr = r_sidx[CELL_W-1:0];
        l_we    = 1'b0;
        l_waddr = r_tail[CELL_W-1:0];
        l_wdata = {r_nr, r_nc};
        l_raddr = r_head[CELL_W-1:0];
        case (r_state)
            S_IDLE: begin
                g_we = in_acc && (r_load < total);
            end
            S_CLR: begin
                v_we = 1'b1;
            end
            S_SCAN_CHK: begin
                v_we    = !vis_q;
                v_wdata = 1'b1;
            end
            S_NB_RD: begin
                g_raddr = f_flat(nb_r, nb_c, n_eff);
                v_raddr = f_flat(nb_r, nb_c, n_eff);
            end
            S_NB_CHK: begin
                if (!r_bfs) begin
                    l_we    = join_ok;
                    l_waddr = '0;
                    l_wdata = {r_cr, r_cc};
                end else begin
                    l_we    = join_ok;
                    v_we    = join_ok;
                    v_waddr = r_nflat;
                    v_wdata = 1'b1;
                end
            end
            S_POP_LST: begin
                g_raddr = list_flat;
            end
            S_WB_RD: begin
                l_raddr = r_wi[CELL_W-1:0];
            end
            S_WB_LST: begin
                g_raddr = list_flat;
            end
            S_WB_W: begin
                g_we    = 1'b1;
                g_waddr = r_wflat;
                g_wdata = r_mean;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load      <= '0;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
            r_days      <= '0;
            r_joined    <= 1'b0;
            r_changed   <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_sum       <= '0;
        end else begin
            if (out_acc && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_last_cell) begin
                            r_load  <= '0;
                            r_days  <= '0;
                            r_sidx  <= '0;
                            r_state <= S_CLR;
                        end else if (r_load < total) begin
                            r_load <= r_load + 1'b1;
                        end else begin
                            r_load <= total;
                        end
                    end
                end
                S_CLR: begin
                    if (scan_end) begin
                        r_sidx    <= '0;
                        r_sr      <= '0;
                        r_sc      <= '0;
                        r_joined  <= 1'b0;
                        r_changed <= 1'b0;
                        r_state   <= S_SCAN_RD;
                    end else begin
                        r_sidx <= r_sidx + 1'b1;
                    end
                end
                S_SCAN_RD: begin
                    r_state <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (vis_q) begin
                        r_sidx <= r_sidx + 1'b1;
                        r_sc   <= col_wrap ? '0 : r_sc + 1'b1;
                        r_sr   <= col_wrap ? r_sr + 1'b1 : r_sr;
                        r_state <= scan_end ? S_PASS_END : S_SCAN_RD;
                    end else begin
                        r_gcur  <= grid_q;
                        r_cr    <= r_sr;
                        r_cc    <= r_sc;
                        r_k     <= K_UP;
                        r_bfs   <= 1'b0;
                        r_state <= S_NB_RD;
                    end
                end
                S_NB_RD: begin
                    r_nr    <= nb_r;
                    r_nc    <= nb_c;
                    r_nflat <= f_flat(nb_r, nb_c, n_eff);
                    if (nb_ok) begin
                        r_state <= S_NB_CHK;
                    end else if (!k_last) begin
                        r_k <= r_k + 1'b1;
                    end else if (!r_bfs) begin
                        r_sidx <= r_sidx + 1'b1;
                        r_sc   <= col_wrap ? '0 : r_sc + 1'b1;
                        r_sr   <= col_wrap ? r_sr + 1'b1 : r_sr;
                        r_state <= scan_end ? S_PASS_END : S_SCAN_RD;
                    end else begin
                        r_head <= r_head + 1'b1;
                        if ((r_head + 1'b1) < r_tail) begin
                            r_state <= S_POP_RD;
                        end else begin
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end
                    end
                end
                S_NB_CHK: begin
                    if (!r_bfs && join_ok) begin
                        // seed found: start a region with this cell
                        r_joined <= 1'b1;
                        r_head   <= '0;
                        r_tail   <= TOT_W'(1);
                        r_sum    <= '0;
                        r_state  <= S_POP_RD;
                    end else begin
                        if (r_bfs && join_ok) begin
                            r_tail <= r_tail + 1'b1;
                        end
                        if (!k_last) begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_NB_RD;
                        end else if (!r_bfs) begin
                            r_sidx <= r_sidx + 1'b1;
                            r_sc   <= col_wrap ? '0 : r_sc + 1'b1;
                            r_sr   <= col_wrap ? r_sr + 1'b1 : r_sr;
                            r_state <= scan_end ? S_PASS_END : S_SCAN_RD;
                        end else begin
                            r_head <= r_head + 1'b1;
                            if ((r_head + 1'b1) < (join_ok ? r_tail + 1'b1 : r_tail)) begin
                                r_state <= S_POP_RD;
                            end else begin
                                r_div_go <= 1'b1;
                                r_state  <= S_DIV;
                            end
                        end
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP_LST;
                end
                S_POP_LST: begin
                    r_cr    <= list_q[2*RC_W-1:RC_W];
                    r_cc    <= list_q[RC_W-1:0];
                    r_state <= S_POP_CUR;
                end
                S_POP_CUR: begin
                    r_gcur  <= grid_q;
                    r_sum   <= r_sum + SUM_W'(grid_q);
                    r_k     <= K_UP;
                    r_bfs   <= 1'b1;
                    r_state <= S_NB_RD;
                end
                S_DIV: begin
                    r_div_go <= 1'b0;
                    if (div_out.done) begin
                        r_mean  <= quot[VALUE_BITS-1:0];
                        r_wi    <= '0;
                        r_state <= S_WB_RD;
                    end
                end
                S_WB_RD: begin
                    r_state <= S_WB_LST;
                end
                S_WB_LST: begin
                    r_wflat <= list_flat;
                    r_state <= S_WB_W;
                end
                S_WB_W: begin
                    if (grid_q != r_mean) begin
                        r_changed <= 1'b1;
                    end
                    r_wi <= r_wi + 1'b1;
                    if ((r_wi + 1'b1) == r_tail) begin
                        r_sidx <= r_sidx + 1'b1;
                        r_sc   <= col_wrap ? '0 : r_sc + 1'b1;
                        r_sr   <= col_wrap ? r_sr + 1'b1 : r_sr;
                        r_state <= scan_end ? S_PASS_END : S_SCAN_RD;
                    end else begin
                        r_state <= S_WB_RD;
                    end
                end
                S_PASS_END: begin
                    r_sidx <= '0;
                    if (!r_joined) begin
                        r_state <= S_DONE;
                    end else if (!r_changed) begin
                        // merges that leave the grid unchanged repeat forever
                        r_days  <= DAY_MAX;
                        r_state <= S_DONE;
                    end else begin
                        r_days  <= r_days + 1'b1;
                        r_state <= ((r_days + 1'b1) == DAY_MAX) ? S_DONE : S_CLR;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_day_out   <= r_days;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_day_count = r_day_out;

`ifndef SYNTHESIS
    a_pop_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP_RD |-> r_head < r_tail)
        else $error("pop beyond region list tail");
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> (r_tail != '0 && r_tail <= total))
        else $error("region size out of range");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_out.done |-> r_state == S_DIV)
        else $error("divider finished outside mean state");
    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_load <= total)
        else $error("load index past grid size");
    a_wb_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_WB_RD) && $past(r_state) == S_DIV |-> r_wi == '0)
        else $error("write-back did not start at list head");
`endif

endmodule

// ===== verif/grid_region_merge_average_unit_tb.sv =====
// Testbench for grid_region_merge_average_unit: directed grids, then random grids.
// Day counts are predicted by a flood-fill region-averaging model held here.
// Depends on grma_pkg and the RTL top level.
`timescale 1ns / 1ps

module grid_region_merge_average_unit_tb;
    import grma_pkg::*;

    localparam int MAX_SIDE   = 64;
    localparam int CELL_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int WATCH_LIMIT = 3000000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int NO_EXP = -1;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_cell_value = '0;
    logic        i_last_cell = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_day_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    grid_region_merge_average_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_cell_value(i_cell_value), .i_last_cell(i_last_cell),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_day_count(o_day_count),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // predictor state
    int unsigned cell_mem [CELL_COUNT];
    bit          cell_written [CELL_COUNT];
    bit          cell_seen [CELL_COUNT];
    int          region_cells [CELL_COUNT];
    int          region_tail;
    bit          grid_changed;
    int          load_pos;
    int unsigned side_reg, lo_reg, hi_reg;
    logic [15:0] day_count_q [$];

    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    function automatic int eff_side();
        if (side_reg == 0) return 1;
        if (side_reg > MAX_SIDE) return MAX_SIDE;
        return side_reg;
    endfunction

    function automatic int nb_index(int n, int idx, logic [1:0] k);
        int r, c;
        r = idx / n;
        c = idx % n;
        case (k)
            K_UP:    r = r - 1;
            K_DOWN:  r = r + 1;
            K_LEFT:  c = c - 1;
            default: c = c + 1;
        endcase
        if (r < 0 || c < 0 || r >= n || c >= n) return -1;
        return r * n + c;
    endfunction

    function automatic bit can_join(int a, int b);
        int unsigned d;
        if (b < 0) return 0;
        if (cell_seen[b]) return 0;
        d = (cell_mem[a] > cell_mem[b]) ? cell_mem[a] - cell_mem[b]
                                        : cell_mem[b] - cell_mem[a];
        return (lo_reg <= d) && (d <= hi_reg);
    endfunction

    function automatic void grow_region(int n, int seed);
        int start, head, cur, nb;
        longint unsigned sum;
        int unsigned mean;
        start = region_tail;
        region_cells[region_tail] = seed;
        region_tail++;
        cell_seen[seed] = 1;
        sum = 0;
        head = start;
        while (head < region_tail) begin
            cur = region_cells[head];
            head++;
            sum += cell_mem[cur];
            for (int k = 0; k < 4; k++) begin
                nb = nb_index(n, cur, k[1:0]);
                if (can_join(cur, nb) && region_tail < CELL_COUNT) begin
                    region_cells[region_tail] = nb;
                    region_tail++;
                    cell_seen[nb] = 1;
                end
            end
        end
        mean = int'(sum / longint'(region_tail - start));
        for (int i = start; i < region_tail; i++) begin
            if (cell_mem[region_cells[i]] != mean) grid_changed = 1;
            cell_mem[region_cells[i]] = mean;
        end
    endfunction

    function automatic bit merge_pass(int n);
        bit joined;
        joined = 0;
        for (int i = 0; i < CELL_COUNT; i++) cell_seen[i] = 0;
        region_tail = 0;
        grid_changed = 0;
        for (int idx = 0; idx < n * n; idx++) begin
            if (!cell_seen[idx]) begin
                cell_seen[idx] = 1;
                for (int k = 0; k < 4; k++) begin
                    if (can_join(idx, nb_index(n, idx, k[1:0]))) begin
                        grow_region(n, idx);
                        joined = 1;
                        break;
                    end
                end
            end
        end
        return joined;
    endfunction

    function automatic logic [15:0] count_days(int n);
        int unsigned days;
        days = 0;
        while (days < DAY_MAX) begin
            if (!merge_pass(n)) break;
            if (!grid_changed) begin
                days = DAY_MAX;
                break;
            end
            days++;
        end
        return days[15:0];
    endfunction

    // model update for one accepted cell beat
    function automatic void take_cell(logic [15:0] v, logic last);
        int n;
        n = eff_side();
        if (load_pos < n * n) begin
            cell_mem[load_pos] = v;
            cell_written[load_pos] = 1;
            load_pos++;
        end else begin
            load_pos = n * n;
        end
        if (last) begin
            day_count_q = {day_count_q, count_days(n)};
            load_pos = 0;
        end
    endfunction

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SIDE:  side_reg = val[6:0];
            REG_DLOW:  lo_reg = val[15:0];
            default:   hi_reg = val[15:0];
        endcase
    endtask

    // block is already idle when the last expected result leaves
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (day_count_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_limits(int unsigned side, int unsigned lo, int unsigned hi);
        wait_idle();
        reg_write(REG_SIDE, side);
        reg_write(REG_DLOW, lo);
        reg_write(REG_DHIGH, hi);
    endtask

    task automatic send_cell(logic [15:0] v, logic last);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_value <= v;
        i_last_cell <= last;
        do @(posedge i_clk); while (o_in_stall);
        take_cell(v, last);
        items_sent++;
    endtask

    // are all cells from k up to total already loaded at some earlier point
    function automatic bit rest_written(int k, int total);
        for (int i = k; i < total; i++) if (!cell_written[i]) return 0;
        return 1;
    endfunction

    typedef struct {
        int unsigned side;
        int unsigned lo;
        int unsigned hi;
        int          cnt;
        logic [15:0] vals [4];
        int          exp_days;
    } t_grid_row;

    t_grid_row grid_rows [9] = '{
        '{1, 0, 65535, 1, '{16'hFFFF, 0, 0, 0}, 0},
        '{2, 5, 2, 4, '{1, 3, 9, 4}, 0},                  // limits crossed
        '{2, 0, 65535, 4, '{7, 7, 7, 7}, 65535},          // joins, no change
        '{2, 0, 65535, 4, '{0, 16'hFFFF, 0, 16'hFFFF}, 65535},
        '{0, 0, 65535, 1, '{5, 0, 0, 0}, 0},              // side 0 acts as 1
        '{1, 0, 65535, 3, '{16'h8000, 1, 2, 0}, 0},       // surplus cells dropped
        '{2, 0, 0, 4, '{3, 3, 3, 4}, 65535},
        '{2, 1, 10, 4, '{0, 4, 8, 12}, NO_EXP},
        '{2, 1, 10, 1, '{16'h5555, 0, 0, 0}, NO_EXP}     // early last cell
    };

    initial begin
        int n, total, cnt, k, gi, mode;
        logic [15:0] v;
        side_reg = 64;
        lo_reg = 0;
        hi_reg = 65535;
        load_pos = 0;
        for (int i = 0; i < CELL_COUNT; i++) cell_written[i] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (grid_rows[r]) begin
            set_limits(grid_rows[r].side, grid_rows[r].lo, grid_rows[r].hi);
            for (int i = 0; i < grid_rows[r].cnt; i++)
                send_cell(grid_rows[r].vals[i], i == grid_rows[r].cnt - 1);
            if (grid_rows[r].exp_days != NO_EXP &&
                day_count_q[$] != grid_rows[r].exp_days[15:0]) begin
                $display("%0t directed row %0d: expected %0d, model gives %0d",
                         $time, r, grid_rows[r].exp_days, day_count_q[$]);
                errors++;
            end
        end

        gi = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case ((gi / 6) % 5)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                3: begin idle_pct = 8;  stall_pct = 8;  end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            if ($urandom_range(3) != 0) begin
                k = $urandom_range(9);
                set_limits(k == 0 ? $urandom_range(12) : $urandom_range(8, 1),
                           k == 1 ? 65535 : $urandom_range(4),
                           k == 2 ? 65535 : (k == 3 ? 0 : $urandom_range(24)));
            end
            n = eff_side();
            total = n * n;
            cnt = total;
            k = $urandom_range(99);
            if (k < 15) begin
                cnt = total + $urandom_range(3, 1);
            end else if (k < 30 && total > 1) begin
                cnt = $urandom_range(total - 1, 1);
                if (!rest_written(cnt, total)) cnt = total;
            end
            mode = $urandom_range(9);
            for (int i = 0; i < cnt; i++) begin
                v = (mode == 0) ? 16'($urandom_range(65535))
                  : (mode == 1) ? 16'hFFF0 + 16'($urandom_range(15))
                  : 16'($urandom_range(15));
                send_cell(v, i == cnt - 1);
            end
            gi++;
        end
        i_in_valid <= 1'b0;
        i_last_cell <= 1'b0;

        while (day_count_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (day_count_q.size() == 0) begin
                $display("%0t unexpected result beat: expected none, actual %0d",
                         $time, o_day_count);
                errors++;
            end else begin
                if (o_day_count !== day_count_q[0]) begin
                    $display("%0t day_count mismatch: expected %0d, actual %0d",
                             $time, day_count_q[0], o_day_count);
                    errors++;
                end
                void'(day_count_q.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCH_LIMIT) begin
                $display("%0t watchdog: no beat accepted for %0d cycles",
                         $time, WATCH_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule
